// ===== hw/rtl/pss_pkg.sv =====
`timescale 1ns / 1ps

package pss_pkg;

	localparam int CntW   = 16;
	localparam int CurW   = 12;
	localparam int StatW  = 3;
	localparam int KindW  = 2;
	localparam int CfgIdxW = 1;
	localparam int CfgDataW = 16;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PRESS = 2'd1,
		PH_AFTER = 2'd2,
		PH_RAISE = 2'd3
	} phase_t;

	localparam logic [StatW-1:0] ST_OK            = 3'd0;
	localparam logic [StatW-1:0] ST_RAISE_TIMEOUT = 3'd1;
	localparam logic [StatW-1:0] ST_OVERCURRENT   = 3'd2;
	localparam logic [StatW-1:0] ST_PRESS_TIMEOUT = 3'd3;
	localparam logic [StatW-1:0] ST_AFTER_TIMEOUT = 3'd4;

	localparam logic [KindW-1:0] KIND_TICK  = 2'd0;
	localparam logic [KindW-1:0] KIND_PRESS = 2'd1;
	localparam logic [KindW-1:0] KIND_RAISE = 2'd2;

	localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 1'd0;
	localparam logic [CfgIdxW-1:0] CFG_LIMIT   = 1'd1;

	localparam logic [CntW-1:0] TIMEOUT_RST = 16'd300;
	localparam logic [CurW-1:0] LIMIT_RST   = 12'd2866;

	typedef struct packed {
		phase_t            phase;
		logic [CntW-1:0]   cnt;
		logic [StatW-1:0]  held;
	} seq_state_t;

	typedef struct packed {
		logic [1:0]        phase;
		logic [StatW-1:0]  status;
		logic              done;
		logic              busy;
		logic              drive_up;
		logic              drive_down;
	} seq_res_t;

endpackage

// ===== hw/rtl/pss_step.sv =====
`timescale 1ns / 1ps

module pss_step (
	input  pss_pkg::seq_state_t          cur,
	input  logic [pss_pkg::KindW-1:0]    kind,
	input  logic [pss_pkg::CurW-1:0]     current_sample,
	input  logic                         lower_switch,
	input  logic                         upper_switch,
	input  logic [pss_pkg::CntW-1:0]     timeout_ticks,
	input  logic [pss_pkg::CurW-1:0]     current_limit,
	output pss_pkg::seq_state_t          nxt,
	output pss_pkg::seq_res_t            res
);

	logic                       critical;
	logic [pss_pkg::CntW-1:0]   cnt_inc;
	logic                       out_of_ticks;
	logic                       done;
	logic [pss_pkg::StatW-1:0]  status;

	assign critical     = current_sample >= current_limit;
	assign cnt_inc      = (cur.cnt == '1) ? cur.cnt : cur.cnt + 1'b1;
	assign out_of_ticks = cnt_inc >= timeout_ticks;

	always_comb begin
		nxt    = cur;
		done   = 1'b0;
		status = pss_pkg::ST_OK;
		if (kind == pss_pkg::KIND_PRESS) begin
			if (cur.phase == pss_pkg::PH_IDLE) begin
				nxt.phase = pss_pkg::PH_PRESS;
				nxt.cnt   = '0;
				nxt.held  = pss_pkg::ST_OK;
			end
		end else if (kind == pss_pkg::KIND_RAISE) begin
			if (cur.phase == pss_pkg::PH_IDLE) begin
				nxt.phase = pss_pkg::PH_RAISE;
				nxt.cnt   = '0;
				nxt.held  = pss_pkg::ST_OK;
			end
		end else if (kind == pss_pkg::KIND_TICK && cur.phase != pss_pkg::PH_IDLE) begin
			nxt.cnt = cnt_inc;
			unique case (cur.phase)
				pss_pkg::PH_PRESS: begin
					// lower switch wins over overcurrent and timeout: no error is held, but overcurrent still raises
					if (lower_switch) begin
						nxt.cnt   = '0;
						nxt.phase = critical ? pss_pkg::PH_RAISE : pss_pkg::PH_AFTER;
					end else if (critical) begin
						nxt.phase = pss_pkg::PH_RAISE;
						nxt.cnt   = '0;
						nxt.held  = pss_pkg::ST_OVERCURRENT;
					end else if (out_of_ticks) begin
						nxt.phase = pss_pkg::PH_RAISE;
						nxt.cnt   = '0;
						nxt.held  = pss_pkg::ST_PRESS_TIMEOUT;
					end
				end
				pss_pkg::PH_AFTER: begin
					if (critical) begin
						nxt.phase = pss_pkg::PH_RAISE;
						nxt.cnt   = '0;
					end else if (out_of_ticks) begin
						nxt.phase = pss_pkg::PH_RAISE;
						nxt.cnt   = '0;
						nxt.held  = pss_pkg::ST_AFTER_TIMEOUT;
					end
				end
				pss_pkg::PH_RAISE: begin
					if (upper_switch || out_of_ticks) begin
						done = 1'b1;
						// earlier error takes precedence over the raise result
						if (cur.held != pss_pkg::ST_OK)
							status = cur.held;
						else if (out_of_ticks)
							status = pss_pkg::ST_RAISE_TIMEOUT;
						nxt.phase = pss_pkg::PH_IDLE;
						nxt.cnt   = '0;
						nxt.held  = pss_pkg::ST_OK;
					end
				end
				default: begin
					nxt = cur;
				end
			endcase
		end
	end

	always_comb begin
		res.drive_down = (nxt.phase == pss_pkg::PH_PRESS) || (nxt.phase == pss_pkg::PH_AFTER);
		res.drive_up   = nxt.phase == pss_pkg::PH_RAISE;
		res.busy       = nxt.phase != pss_pkg::PH_IDLE;
		res.done       = done;
		res.status     = status;
		res.phase      = nxt.phase;
	end

endmodule

// ===== hw/rtl/press_stroke_sequencer.sv =====
`timescale 1ns / 1ps

// Press stroke sequencer.
// Input stream (s_axis): one transfer per command or sample tick. tuser holds
// the kind (tick, start press, start raise); tdata holds the current sample
// and both limit switches. Output stream (m_axis): exactly one transfer per
// input transfer, carrying the drive outputs, phase, and on the transfer that
// ends a raise the done flag and the stroke status.
// Each item passes through the input register, then the result register.
// Throughput is one item per cycle while the receiver keeps up, set by the
// single step of the phase/counter update between the two registers.
// The result register is loaded whenever it is empty or being taken; when the
// receiver stalls, one result waits in the result register, one more item
// parks in the input register and then s_axis_tready drops.
// Reset clears the phase to idle, the tick counter and held error to zero,
// and loads timeout 300 and current limit 2866. Configuration is written
// through cfg_we/cfg_addr/cfg_wdata (0 timeout ticks, 1 current limit).
module press_stroke_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pss_pkg::CfgIdxW-1:0]     cfg_addr,
	input  logic [pss_pkg::CfgDataW-1:0]    cfg_wdata,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [11:0] current_sample, [12] lower_switch, [13] upper_switch
	input  logic [15:0]                     s_axis_tdata,
	// [1:0] kind
	input  logic [1:0]                      s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [0] drive_down, [1] drive_up, [2] busy_res, [3] done_res,
	// [6:4] status, [8:7] phase
	output logic [15:0]                     m_axis_tdata
);

	logic [pss_pkg::CntW-1:0]   timeout_q;
	logic [pss_pkg::CurW-1:0]   limit_q;
	pss_pkg::seq_state_t        state_q;
	pss_pkg::seq_state_t        state_nxt;
	pss_pkg::seq_res_t          res_nxt;

	logic                       vld_s1;
	logic [pss_pkg::KindW-1:0]  kind_s1;
	logic [pss_pkg::CurW-1:0]   sample_s1;
	logic                       lower_s1;
	logic                       upper_s1;

	logic                       vld_s2;
	pss_pkg::seq_res_t          res_s2;

	logic                       advance;

	assign advance       = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= pss_pkg::TIMEOUT_RST;
			limit_q   <= pss_pkg::LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				pss_pkg::CFG_TIMEOUT: timeout_q <= cfg_wdata;
				pss_pkg::CFG_LIMIT:   limit_q   <= cfg_wdata[pss_pkg::CurW-1:0];
				default:              timeout_q <= timeout_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1   <= s_axis_tuser;
			sample_s1 <= s_axis_tdata[pss_pkg::CurW-1:0];
			lower_s1  <= s_axis_tdata[12];
			upper_s1  <= s_axis_tdata[13];
		end
	end

	pss_step u_step (
		.cur            (state_q),
		.kind           (kind_s1),
		.current_sample (sample_s1),
		.lower_switch   (lower_s1),
		.upper_switch   (upper_s1),
		.timeout_ticks  (timeout_q),
		.current_limit  (limit_q),
		.nxt            (state_nxt),
		.res            (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= pss_pkg::PH_IDLE;
			state_q.cnt   <= '0;
			state_q.held  <= pss_pkg::ST_OK;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!vld_s2 || m_axis_tready) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {7'd0, res_s2};

`ifndef NO_ASSERTIONS
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == pss_pkg::PH_IDLE |-> state_q.cnt == '0 && state_q.held == pss_pkg::ST_OK)
		else $error("idle phase with stale counter or held error");

	a_held_only_raise: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.held != pss_pkg::ST_OK |-> state_q.phase == pss_pkg::PH_RAISE)
		else $error("held error outside raise phase");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && res_s2.done |-> !res_s2.busy && res_s2.phase == pss_pkg::PH_IDLE)
		else $error("done result while still busy");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> state_q == $past(state_q))
		else $error("sequencer state moved without a transfer");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !m_axis_tready |=> vld_s2 && $stable(res_s2))
		else $error("stalled result changed");
`endif

endmodule

// ===== bench/tb_press_stroke_sequencer.sv =====
`timescale 1ns / 1ps

module tb_press_stroke_sequencer;

	localparam logic [pss_pkg::KindW-1:0] KIND_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int ITEM_TARGET = 700;
	localparam int NDIR = 28;
	localparam int TIGHT_ROW = 18;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSED} rx_mode_t;

	typedef struct {
		logic [pss_pkg::KindW-1:0] kind;
		logic [pss_pkg::CurW-1:0]  cur;
		logic                      lo;
		logic                      up;
		bit                        typed;
		pss_pkg::phase_t           ph;
		logic [pss_pkg::StatW-1:0] st;
		logic                      done;
	} stim_row_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [pss_pkg::CfgIdxW-1:0]  cfg_addr = pss_pkg::CFG_TIMEOUT;
	logic [pss_pkg::CfgDataW-1:0] cfg_wdata = '0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [15:0]                  s_tdata = '0;
	logic [1:0]                   s_tuser = pss_pkg::KIND_TICK;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [15:0]                  m_tdata;

	// stroke state as the block should hold it
	pss_pkg::phase_t           ph = pss_pkg::PH_IDLE;
	logic [pss_pkg::CntW-1:0]  ticks = '0;
	logic [pss_pkg::StatW-1:0] held_err = pss_pkg::ST_OK;
	logic [pss_pkg::CntW-1:0]  tmo_reg = pss_pkg::TIMEOUT_RST;
	logic [pss_pkg::CurW-1:0]  lim_reg = pss_pkg::LIMIT_RST;

	pss_pkg::seq_res_t stroke_res_q[$];
	int       mismatches = 0;
	int       burst_left = 0;
	int unsigned cyc = 0;

	logic [3:0] park_seq = '0;
	logic [3:0] park_seen = '0;
	int         park_left = 0;
	int         mode_left = 0;
	rx_mode_t   rx_mode = RX_OPEN;

	stim_row_t dir_rows [NDIR] = '{
		'{pss_pkg::KIND_TICK, 12'd4095, 1'b1, 1'b1, 1'b1,
			pss_pkg::PH_IDLE, pss_pkg::ST_OK, 1'b0},
		'{KIND_UNUSED, 12'd0, 1'b1, 1'b0, 1'b1,
			pss_pkg::PH_IDLE, pss_pkg::ST_OK, 1'b0},
		'{pss_pkg::KIND_PRESS, 12'd0, 1'b0, 1'b0, 1'b1,
			pss_pkg::PH_PRESS, pss_pkg::ST_OK, 1'b0},
		'{pss_pkg::KIND_PRESS, 12'd4095, 1'b1, 1'b1, 1'b1,
			pss_pkg::PH_PRESS, pss_pkg::ST_OK, 1'b0},
		'{pss_pkg::KIND_RAISE, 12'd0, 1'b0, 1'b0, 1'b0,
			pss_pkg::PH_IDLE, pss_pkg::ST_OK, 1'b0},
		'{pss_pkg::KIND_TICK, 12'd0, 1'b0, 1'b0, 1'b1,
			pss_pkg::PH_PRESS, pss_pkg::ST_OK, 1'b0},
		'{pss_pkg::KIND_TICK, 12'd2866, 1'b0, 1'b1, 1'b1,
			pss_pkg::PH_RAISE, pss_pkg::ST_OK, 1'b0},
		'{pss_pkg::KIND_TICK, 12'd0, 1'b0, 1'b1, 1'b1,
			pss_pkg::PH_IDLE, pss_pkg::ST_OVERCURRENT, 1'b1},
		'{pss_pkg::KIND_PRESS, 12'd0, 1'b0, 1'b0, 1'b1,
			pss_pkg::PH_PRESS, pss_pkg::ST_OK, 1'b0},
		'{pss_pkg::KIND_TICK, 12'd2865, 1'b1, 1'b0, 1'b1,
			pss_pkg::PH_AFTER, pss_pkg::ST_OK, 1'b0},
		'{pss_pkg::KIND_TICK, 12'd2866, 1'b0, 1'b0, 1'b1,
			pss_pkg::PH_RAISE, pss_pkg::ST_OK, 1'b0},
		'{KIND_UNUSED, 12'd0, 1'b0, 1'b1, 1'b0,
			pss_pkg::PH_IDLE, pss_pkg::ST_OK, 1'b0},
		'{pss_pkg::KIND_TICK, 12'd0, 1'b1, 1'b1, 1'b1,
			pss_pkg::PH_IDLE, pss_pkg::ST_OK, 1'b1},
		'{pss_pkg::KIND_RAISE, 12'd0, 1'b0, 1'b0, 1'b1,
			pss_pkg::PH_RAISE, pss_pkg::ST_OK, 1'b0},
		'{pss_pkg::KIND_TICK, 12'd0, 1'b0, 1'b1, 1'b1,
			pss_pkg::PH_IDLE, pss_pkg::ST_OK, 1'b1},
		'{pss_pkg::KIND_PRESS, 12'd0, 1'b0, 1'b0, 1'b1,
			pss_pkg::PH_PRESS, pss_pkg::ST_OK, 1'b0},
		'{pss_pkg::KIND_TICK, 12'd4095, 1'b1, 1'b0, 1'b1,
			pss_pkg::PH_RAISE, pss_pkg::ST_OK, 1'b0},
		'{pss_pkg::KIND_TICK, 12'd1234, 1'b0, 1'b1, 1'b1,
			pss_pkg::PH_IDLE, pss_pkg::ST_OK, 1'b1},
		// timeout 1, limit 4095 from here on
		'{pss_pkg::KIND_PRESS, 12'd0, 1'b0, 1'b0, 1'b1,
			pss_pkg::PH_PRESS, pss_pkg::ST_OK, 1'b0},
		'{pss_pkg::KIND_TICK, 12'd4094, 1'b0, 1'b0, 1'b1,
			pss_pkg::PH_RAISE, pss_pkg::ST_OK, 1'b0},
		'{pss_pkg::KIND_TICK, 12'd0, 1'b0, 1'b1, 1'b1,
			pss_pkg::PH_IDLE, pss_pkg::ST_PRESS_TIMEOUT, 1'b1},
		'{pss_pkg::KIND_PRESS, 12'd0, 1'b0, 1'b0, 1'b1,
			pss_pkg::PH_PRESS, pss_pkg::ST_OK, 1'b0},
		'{pss_pkg::KIND_TICK, 12'd0, 1'b1, 1'b0, 1'b0,
			pss_pkg::PH_IDLE, pss_pkg::ST_OK, 1'b0},
		'{pss_pkg::KIND_TICK, 12'd4094, 1'b0, 1'b0, 1'b1,
			pss_pkg::PH_RAISE, pss_pkg::ST_OK, 1'b0},
		'{pss_pkg::KIND_TICK, 12'd0, 1'b0, 1'b0, 1'b1,
			pss_pkg::PH_IDLE, pss_pkg::ST_AFTER_TIMEOUT, 1'b1},
		'{pss_pkg::KIND_RAISE, 12'd0, 1'b0, 1'b0, 1'b1,
			pss_pkg::PH_RAISE, pss_pkg::ST_OK, 1'b0},
		// switch closing on the timeout tick still reports a raise timeout
		'{pss_pkg::KIND_TICK, 12'd0, 1'b0, 1'b1, 1'b1,
			pss_pkg::PH_IDLE, pss_pkg::ST_RAISE_TIMEOUT, 1'b1},
		'{pss_pkg::KIND_TICK, 12'd4095, 1'b0, 1'b0, 1'b1,
			pss_pkg::PH_IDLE, pss_pkg::ST_OK, 1'b0}
	};

	press_stroke_sequencer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic void start_raise(logic [pss_pkg::StatW-1:0] err);
		held_err = err;
		ticks = '0;
		ph = pss_pkg::PH_RAISE;
	endfunction

	function automatic pss_pkg::seq_res_t advance_stroke(logic [pss_pkg::KindW-1:0] kind,
			logic [pss_pkg::CurW-1:0] cur, logic lo, logic up);
		pss_pkg::seq_res_t r;
		logic crit;
		logic fin;
		logic [pss_pkg::StatW-1:0] st;
		crit = cur >= lim_reg;
		fin = 1'b0;
		st = pss_pkg::ST_OK;
		case (kind)
			pss_pkg::KIND_PRESS: begin
				if (ph == pss_pkg::PH_IDLE) begin
					ph = pss_pkg::PH_PRESS;
					ticks = '0;
					held_err = pss_pkg::ST_OK;
				end
			end
			pss_pkg::KIND_RAISE: begin
				if (ph == pss_pkg::PH_IDLE)
					start_raise(pss_pkg::ST_OK);
			end
			pss_pkg::KIND_TICK: begin
				if (ph != pss_pkg::PH_IDLE) begin
					if (ticks != 16'hFFFF)
						ticks = ticks + 16'd1;
					case (ph)
						pss_pkg::PH_PRESS: begin
							if (lo) begin
								if (crit) begin
									start_raise(pss_pkg::ST_OK);
								end else begin
									ph = pss_pkg::PH_AFTER;
									ticks = '0;
								end
							end else if (crit) begin
								start_raise(pss_pkg::ST_OVERCURRENT);
							end else if (ticks >= tmo_reg) begin
								start_raise(pss_pkg::ST_PRESS_TIMEOUT);
							end
						end
						pss_pkg::PH_AFTER: begin
							if (crit)
								start_raise(pss_pkg::ST_OK);
							else if (ticks >= tmo_reg)
								start_raise(pss_pkg::ST_AFTER_TIMEOUT);
						end
						default: begin
							if (up || ticks >= tmo_reg) begin
								// an earlier error outranks the raise result
								if (held_err != pss_pkg::ST_OK)
									st = held_err;
								else
									st = (ticks >= tmo_reg) ? pss_pkg::ST_RAISE_TIMEOUT
										: pss_pkg::ST_OK;
								fin = 1'b1;
								ph = pss_pkg::PH_IDLE;
								ticks = '0;
								held_err = pss_pkg::ST_OK;
							end
						end
					endcase
				end
			end
			default: ;
		endcase
		r.drive_down = (ph == pss_pkg::PH_PRESS || ph == pss_pkg::PH_AFTER);
		r.drive_up = (ph == pss_pkg::PH_RAISE);
		r.busy = (ph != pss_pkg::PH_IDLE);
		r.done = fin;
		r.status = st;
		r.phase = ph;
		return r;
	endfunction

	function automatic logic [pss_pkg::CurW-1:0] pick_current(bit crit);
		if (crit || lim_reg == '0)
			return 12'($urandom_range(int'(lim_reg), 4095));
		else if ($urandom_range(0, 3) == 0)
			return lim_reg - 12'd1;
		else
			return 12'($urandom_range(0, int'(lim_reg) - 1));
	endfunction

	task automatic log_fault(string msg);
		if (mismatches < 10)
			$display("%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Offer one item, wait for the transfer, record what it should produce.
	task automatic send_item(logic [pss_pkg::KindW-1:0] kind, logic [pss_pkg::CurW-1:0] cur,
			logic lo, logic up, bit typed, pss_pkg::seq_res_t typed_res);
		pss_pkg::seq_res_t pred;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {2'b00, up, lo, cur};
		do @(posedge clk); while (!s_tready);
		pred = advance_stroke(kind, cur, lo, up);
		stroke_res_q.push_back(typed ? typed_res : pred);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end
	endtask

	// Drop valid and wait until every outstanding result has been taken.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (stroke_res_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_config(logic [pss_pkg::CfgDataW-1:0] tmo,
			logic [pss_pkg::CfgDataW-1:0] lim_word);
		cfg_we <= 1'b1;
		cfg_addr <= pss_pkg::CFG_TIMEOUT;
		cfg_wdata <= tmo;
		@(posedge clk);
		cfg_addr <= pss_pkg::CFG_LIMIT;
		cfg_wdata <= lim_word;
		@(posedge clk);
		cfg_we <= 1'b0;
		tmo_reg = tmo;
		lim_reg = lim_word[pss_pkg::CurW-1:0];
	endtask

	// Receiver: changing ready pattern, plus a long hold-off on request.
	always @(posedge clk) begin
		if (park_seq != park_seen) begin
			park_seen <= park_seq;
			park_left <= 120;
			m_tready <= 1'b0;
		end else if (park_left != 0) begin
			park_left <= park_left - 1;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				mode_left <= $urandom_range(10, 80);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (rx_mode)
				RX_OPEN:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default:   m_tready <= (cyc[3:1] != 3'd0);
			endcase
		end
	end

	always @(posedge clk) begin
		pss_pkg::seq_res_t got;
		pss_pkg::seq_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[8:0];
			if (stroke_res_q.size() == 0) begin
				log_fault($sformatf("result with none expected: %h", m_tdata));
			end else begin
				want = stroke_res_q.pop_front();
				if (got.drive_down != want.drive_down || got.drive_up != want.drive_up
						|| got.busy != want.busy || got.done != want.done
						|| got.status != want.status || got.phase != want.phase)
					log_fault($sformatf({"mismatch: exp dn=%0d up=%0d busy=%0d done=%0d ",
						"st=%0d ph=%0d, got dn=%0d up=%0d busy=%0d done=%0d st=%0d ph=%0d"},
						want.drive_down, want.drive_up, want.busy, want.done, want.status,
						want.phase, got.drive_down, got.drive_up, got.busy, got.done,
						got.status, got.phase));
			end
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("[press_stroke_sequencer] ERROR");
			$finish;
		end
	end

	initial begin
		pss_pkg::seq_res_t hand_res;
		logic [pss_pkg::KindW-1:0] kind;
		logic [pss_pkg::CurW-1:0] cur;
		logic lo;
		logic up;
		logic [pss_pkg::CfgDataW-1:0] tmo;
		logic [pss_pkg::CfgDataW-1:0] lim_word;
		int roll;
		int n_active;
		int next_cfg;
		int cfg_round;
		n_active = 0;
		next_cfg = 100;
		cfg_round = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NDIR; i++) begin
			if (i == TIGHT_ROW) begin
				settle();
				load_config(16'd1, 16'd4095);
			end
			hand_res.drive_down = (dir_rows[i].ph == pss_pkg::PH_PRESS
				|| dir_rows[i].ph == pss_pkg::PH_AFTER);
			hand_res.drive_up = (dir_rows[i].ph == pss_pkg::PH_RAISE);
			hand_res.busy = (dir_rows[i].ph != pss_pkg::PH_IDLE);
			hand_res.done = dir_rows[i].done;
			hand_res.status = dir_rows[i].st;
			hand_res.phase = dir_rows[i].ph;
			send_item(dir_rows[i].kind, dir_rows[i].cur, dir_rows[i].lo, dir_rows[i].up,
				dir_rows[i].typed, hand_res);
		end
		settle();

		// stall the output for a long stretch while items keep coming
		park_seq <= park_seq + 4'd1;
		while (n_active < ITEM_TARGET) begin
			if (n_active >= next_cfg) begin
				settle();
				case (cfg_round)
					0: begin
						tmo = 16'hFFFF;
						lim_word = 16'h0FFF;
					end
					1: begin
						// zero timeout; upper bits of the limit word are dropped
						tmo = 16'd0;
						lim_word = 16'hF000;
					end
					2: begin
						tmo = 16'd2;
						lim_word = 16'($urandom_range(0, 65535));
					end
					default: begin
						tmo = 16'($urandom_range(1, 30));
						lim_word = 16'($urandom_range(0, 65535));
					end
				endcase
				load_config(tmo, lim_word);
				cfg_round++;
				next_cfg += 110;
			end
			kind = pss_pkg::KIND_TICK;
			cur = 12'($urandom_range(0, 4095));
			lo = 1'($urandom_range(0, 1));
			up = 1'($urandom_range(0, 1));
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				kind = 2'($urandom_range(0, 3));
			end else begin
				case (ph)
					pss_pkg::PH_IDLE:
						kind = (roll < 60) ? pss_pkg::KIND_PRESS : pss_pkg::KIND_RAISE;
					pss_pkg::PH_PRESS: begin
						roll = $urandom_range(0, 99);
						lo = (roll < 10);
						cur = pick_current(roll < 5 || (roll >= 10 && roll < 15));
					end
					pss_pkg::PH_AFTER: cur = pick_current($urandom_range(0, 99) < 15);
					default: up = ($urandom_range(0, 99) < 20);
				endcase
			end
			if ((ph == pss_pkg::PH_IDLE)
					? (kind == pss_pkg::KIND_PRESS || kind == pss_pkg::KIND_RAISE)
					: (kind == pss_pkg::KIND_TICK))
				n_active++;
			send_item(kind, cur, lo, up, 1'b0, '0);
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[press_stroke_sequencer] OK");
		else
			$display("[press_stroke_sequencer] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/pss_pkg.sv
hw/rtl/pss_step.sv
hw/rtl/press_stroke_sequencer.sv
bench/tb_press_stroke_sequencer.sv
